// ===== sv/heat_line_explicit_step_unit_assert.svh =====
// Assertion macros for the heat line step unit.
`ifndef HEAT_LINE_EXPLICIT_STEP_UNIT_ASSERT_SVH
`define HEAT_LINE_EXPLICIT_STEP_UNIT_ASSERT_SVH

// Property checked on every rising clock edge, off while in reset.
`define HLES_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define HLES_ASSERT_IMPL(lbl, ante, cons, msg) \
  `HLES_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== sv/hles_pkg.sv =====
// Types and constants shared by the heat line step unit files.
package hles_pkg;

  localparam int unsigned ValW   = 24;
  localparam int unsigned CoefW  = 16;
  localparam int unsigned CountW = 11;
  localparam int unsigned StepW  = 32;
  localparam int unsigned OpW    = 2;
  localparam int unsigned IdxW   = 10;
  localparam int unsigned LapW   = ValW + 2;
  localparam int unsigned ProdW  = LapW + CoefW + 1;
  localparam int unsigned FracW  = 16;
  localparam int unsigned SumW   = ValW + 4;
  localparam int unsigned AddrW  = 5;
  localparam int unsigned DataW  = 32;

  typedef logic signed [ValW-1:0] value_t;

  typedef enum logic [OpW-1:0] {
    OP_STEP    = 2'd0,
    OP_READ    = 2'd1,
    OP_RESTART = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_COEF  = 3'd0,
    REG_LEFT  = 3'd1,
    REG_RIGHT = 3'd2,
    REG_COUNT = 3'd3,
    REG_LIMIT = 3'd4
  } reg_e;

  localparam logic [CoefW-1:0]  CoefRst  = 16'd6554;
  localparam value_t            LeftRst  = 24'sd0;
  localparam value_t            RightRst = 24'sd655360;
  localparam logic [CountW-1:0] CountRst = 11'd64;
  localparam logic [StepW-1:0]  LimitRst = 32'd100;

  localparam logic signed [SumW-1:0] ValMax = 28'sd8388607;
  localparam logic signed [SumW-1:0] ValMin = -28'sd8388608;

  function automatic value_t sat_val(input logic signed [SumW-1:0] s);
    value_t r;
    if (s > ValMax) begin
      r = value_t'(ValMax);
    end else if (s < ValMin) begin
      r = value_t'(ValMin);
    end else begin
      r = value_t'(s);
    end
    return r;
  endfunction

endpackage

// ===== sv/hles_if.sv =====
// Valid/ready channel interfaces for op items and result items.
interface hles_item_if;
  logic                       valid;
  logic                       ready;
  logic [hles_pkg::OpW-1:0]   op;
  logic [hles_pkg::IdxW-1:0]  node_index;

  modport source (output valid, op, node_index, input ready);
  modport sink   (input valid, op, node_index, output ready);
endinterface

interface hles_result_if;
  logic                        valid;
  logic                        ready;
  logic signed [hles_pkg::ValW-1:0] node_value;
  logic [hles_pkg::StepW-1:0]  steps_done;
  logic                        limit_reached;

  modport source (output valid, node_value, steps_done, limit_reached, input ready);
  modport sink   (input valid, node_value, steps_done, limit_reached, output ready);
endinterface

// ===== sv/heat_line_explicit_step_unit.sv =====
// Top level: 1-D explicit heat step engine with node memory and APB registers.
//
//  channel   dir  handshake      payload
//  item_i    in   valid/ready    op, node_index
//  result_o  out  valid/ready    node_value, steps_done, limit_reached
//  apb       in   psel/penable   paddr, pwdata -> prdata (pready tied high)
//
// Op sequences: a step runs prime, load, a sweep through one shared multiply-add
// pipe, drain and result load; a read runs a read state and result load; a no-op
// or a step past the limit goes to result load; a restart runs a clear pass (one
// entry a cycle), then result load. The same clear pass runs after reset, with
// item_i not ready. item_i is taken while the previous result waits; a finished
// op holds until the result register is free.
`include "heat_line_explicit_step_unit_assert.svh"

module heat_line_explicit_step_unit #(
  parameter int unsigned MaxNodes = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  hles_item_if.sink                       item_i,
  hles_result_if.source                   result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [hles_pkg::AddrW-1:0]      paddr,
  input  logic [hles_pkg::DataW-1:0]      pwdata,
  output logic [hles_pkg::DataW-1:0]      prdata,
  output logic                            pready
);

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam int unsigned NW = $clog2(MaxNodes + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PRIME,
    ST_LOAD,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_EMIT
  } state_e;

  // Configuration registers
  logic [hles_pkg::CoefW-1:0]  coef_q;
  hles_pkg::value_t            left_q;
  hles_pkg::value_t            right_q;
  logic [hles_pkg::CountW-1:0] count_q;
  logic [hles_pkg::StepW-1:0]  step_limit_q;

  state_e                      state_q;
  logic                        clr_emit_q;
  logic [AW-1:0]               clr_q;
  logic [AW-1:0]               j_q;
  logic [hles_pkg::StepW-1:0]  step_count_q;
  hles_pkg::value_t            prev_q;
  hles_pkg::value_t            cur_q;
  hles_pkg::value_t            rdata_q;
  hles_pkg::value_t            res_q;
  logic [hles_pkg::IdxW-1:0]   idx_q;
  logic                        pvld_q;
  logic [AW-1:0]               pidx_q;
  hles_pkg::value_t            pcur_q;
  logic signed [hles_pkg::ProdW-1:0] prod_q;
  logic                        out_vld_q;
  hles_pkg::value_t            out_value_q;
  logic [hles_pkg::StepW-1:0]  out_steps_q;
  logic                        out_lim_q;

  hles_pkg::value_t            node_mem [MaxNodes];

  logic [NW-1:0]               n_eff;
  logic [NW-1:0]               n_last;
  logic                        cfg_wr;
  logic                        item_xfer;
  logic                        out_free;
  logic                        below_limit;
  logic                        sweep_last;
  hles_pkg::value_t            next_v;
  logic signed [hles_pkg::LapW-1:0]  lap;
  logic signed [hles_pkg::CoefW:0]   coef_s;
  logic signed [hles_pkg::ProdW-1:0] prod_d;
  logic signed [hles_pkg::ProdW-hles_pkg::FracW-1:0] delta;
  logic signed [hles_pkg::SumW-1:0]  upd_sum;
  hles_pkg::value_t            read_val;
  logic                        mem_we;
  logic [AW-1:0]               mem_wa;
  hles_pkg::value_t            mem_wd;
  logic [AW-1:0]               mem_ra;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q       <= hles_pkg::CoefRst;
      left_q       <= hles_pkg::LeftRst;
      right_q      <= hles_pkg::RightRst;
      count_q      <= hles_pkg::CountRst;
      step_limit_q <= hles_pkg::LimitRst;
    end else if (cfg_wr) begin
      unique case (hles_pkg::reg_e'(paddr[4:2]))
        hles_pkg::REG_COEF:  coef_q       <= pwdata[hles_pkg::CoefW-1:0];
        hles_pkg::REG_LEFT:  left_q       <= hles_pkg::value_t'(pwdata[hles_pkg::ValW-1:0]);
        hles_pkg::REG_RIGHT: right_q      <= hles_pkg::value_t'(pwdata[hles_pkg::ValW-1:0]);
        hles_pkg::REG_COUNT: count_q      <= pwdata[hles_pkg::CountW-1:0];
        hles_pkg::REG_LIMIT: step_limit_q <= pwdata[hles_pkg::StepW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (hles_pkg::reg_e'(paddr[4:2]))
      hles_pkg::REG_COEF:  prdata = hles_pkg::DataW'(coef_q);
      hles_pkg::REG_LEFT:  prdata = hles_pkg::DataW'(left_q);
      hles_pkg::REG_RIGHT: prdata = hles_pkg::DataW'(right_q);
      hles_pkg::REG_COUNT: prdata = hles_pkg::DataW'(count_q);
      hles_pkg::REG_LIMIT: prdata = step_limit_q;
      default:             prdata = '0;
    endcase
  end

  // ---------------- line length and handshakes ----------------
  always_comb begin
    if (count_q < hles_pkg::CountW'(3)) begin
      n_eff = NW'(3);
    end else if (32'(count_q) > 32'(MaxNodes)) begin
      n_eff = NW'(MaxNodes);
    end else begin
      n_eff = NW'(count_q);
    end
  end
  assign n_last = n_eff - NW'(1);

  assign item_i.ready    = (state_q == ST_IDLE);
  assign item_xfer       = item_i.valid && item_i.ready;
  assign out_free        = !out_vld_q || result_o.ready;
  assign below_limit     = step_count_q < step_limit_q;

  assign result_o.valid         = out_vld_q;
  assign result_o.node_value    = out_value_q;
  assign result_o.steps_done    = out_steps_q;
  assign result_o.limit_reached = out_lim_q;

  // ---------------- shared update datapath ----------------
  // Stage B: laplacian of the window and the multiply.
  assign sweep_last = (NW'(j_q) + NW'(1)) == n_last;
  assign next_v     = sweep_last ? right_q : rdata_q;
  assign lap        = hles_pkg::LapW'(prev_q) + hles_pkg::LapW'(next_v)
                    - (hles_pkg::LapW'(cur_q) <<< 1);
  assign coef_s     = $signed({1'b0, coef_q});
  assign prod_d     = lap * coef_s;

  // Stage C: drop the fraction (floor), add and saturate.
  assign delta   = prod_q[hles_pkg::ProdW-1:hles_pkg::FracW];
  assign upd_sum = hles_pkg::SumW'(pcur_q) + hles_pkg::SumW'(delta);

  always_comb begin
    if (idx_q == '0) begin
      read_val = left_q;
    end else if (32'(idx_q) == 32'(n_last)) begin
      read_val = right_q;
    end else if (32'(idx_q) < 32'(n_eff)) begin
      read_val = rdata_q;
    end else begin
      read_val = '0;
    end
  end

  // ---------------- node memory ports ----------------
  always_comb begin
    mem_we = 1'b0;
    mem_wa = pidx_q;
    mem_wd = hles_pkg::sat_val(upd_sum);
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (pvld_q) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    unique case (state_q)
      ST_IDLE:  mem_ra = AW'(item_i.node_index);
      ST_PRIME: mem_ra = AW'(1);
      ST_LOAD:  mem_ra = AW'(2);
      ST_SWEEP: mem_ra = j_q + AW'(2);
      default:  mem_ra = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      node_mem[mem_wa] <= mem_wd;
    end
    rdata_q <= node_mem[mem_ra];
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_emit_q   <= 1'b0;
      clr_q        <= '0;
      j_q          <= '0;
      step_count_q <= '0;
      pvld_q       <= 1'b0;
      out_vld_q    <= 1'b0;
    end else begin
      pvld_q <= (state_q == ST_SWEEP);
      if ((state_q == ST_EMIT) && out_free) begin
        out_vld_q <= 1'b1;
      end else if (result_o.ready) begin
        out_vld_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MaxNodes - 1)) begin
            state_q <= clr_emit_q ? ST_EMIT : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (item_xfer) begin
            res_q <= '0;
            idx_q <= item_i.node_index;
            unique case (hles_pkg::op_e'(item_i.op))
              hles_pkg::OP_STEP:    state_q <= below_limit ? ST_PRIME : ST_EMIT;
              hles_pkg::OP_READ:    state_q <= ST_READ;
              hles_pkg::OP_RESTART: begin
                state_q      <= ST_CLEAR;
                clr_q        <= '0;
                clr_emit_q   <= 1'b1;
                step_count_q <= '0;
              end
              hles_pkg::OP_NOP:     state_q <= ST_EMIT;
              default:              state_q <= ST_EMIT;
            endcase
          end
        end
        ST_PRIME: begin
          prev_q  <= left_q;
          j_q     <= AW'(1);
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          cur_q   <= rdata_q;
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          prod_q <= prod_d;
          pcur_q <= cur_q;
          pidx_q <= j_q;
          prev_q <= cur_q;
          cur_q  <= next_v;
          j_q    <= j_q + AW'(1);
          if (sweep_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last write lands this cycle
          step_count_q <= step_count_q + hles_pkg::StepW'(1);
          state_q      <= ST_EMIT;
        end
        ST_READ: begin
          res_q   <= read_val;
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_value_q <= res_q;
            out_steps_q <= step_count_q;
            out_lim_q   <= !below_limit;
            clr_emit_q  <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  `HLES_ASSERT_IMPL(a_sweep_below_limit, state_q == ST_SWEEP, step_count_q < step_limit_q,
                    "step sweep running at or past the step limit")
  `HLES_ASSERT_IMPL(a_write_interior, mem_we && (state_q != ST_CLEAR),
                    (mem_wa != '0) && (NW'(mem_wa) < n_last),
                    "sweep wrote a boundary or out-of-line node")
  `HLES_ASSERT_IMPL(a_pipe_index, pvld_q, pidx_q == $past(j_q),
                    "write-back index does not follow the sweep index")
  `HLES_ASSERT_IMPL(a_sweep_window, state_q == ST_SWEEP, (j_q != '0) && (NW'(j_q) < n_last),
                    "sweep index left the interior")

endmodule
